>>> src/ghacc_pkg.sv
// Shared types and constants for the GHASH accumulator core.
// Used by ghacc_front, ghacc_queue, ghacc_back and ghash_accumulator_core.
`timescale 1ns / 1ps
`default_nettype none

package ghacc_pkg;

    localparam int HALF_W      = 64;
    localparam int BLOCK_W     = 2 * HALF_W;
    localparam int BLOCK_BYTES = BLOCK_W / 8;
    localparam int BCNT_W      = 5;
    localparam int CNT_W       = 32;
    localparam int CMD_W       = 2;

    // s_tdata: block_hi, block_lo, byte_count, zero padded to whole bytes
    localparam int S_TDATA_W   = ((BLOCK_W + BCNT_W + 7) / 8) * 8;

    // multiplier digit: H is consumed 32 bits per cycle
    localparam int DIGIT_W     = 32;
    localparam int DIGITS      = BLOCK_W / DIGIT_W;
    localparam int DIG_IDX_W   = $clog2(DIGITS);

    // x^128 = x^7 + x^2 + x + 1
    localparam logic [7:0] GF_POLY_LO = 8'h87;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // APB map: 64-bit registers on an 8-byte stride
    localparam int APB_DATA_W  = 64;
    localparam int APB_ADDR_W  = 4;
    localparam int REG_LSB     = 3;

    typedef logic [APB_ADDR_W-REG_LSB-1:0] reg_idx_t;
    localparam reg_idx_t REG_KEY_HI = 1'b0;
    localparam reg_idx_t REG_KEY_LO = 1'b1;

    typedef logic [CMD_W-1:0] cmd_t;
    localparam cmd_t CMD_CLEAR  = 2'd0;
    localparam cmd_t CMD_AAD    = 2'd1;
    localparam cmd_t CMD_TEXT   = 2'd2;
    localparam cmd_t CMD_FINISH = 2'd3;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_PASS,
        OP_MUL
    } op_t;

    typedef struct packed {
        op_t                op;
        logic               fin;
        logic [BLOCK_W-1:0] data;
    } qentry_t;

endpackage

`default_nettype wire

>>> src/ghash_accumulator_core.sv
// Top level of the GHASH accumulator: APB key registers, front end, queue
// and back end. Depends on ghacc_pkg, ghacc_front, ghacc_queue, ghacc_back.
//
// GHASH engine for GCM. Write H to hash_key_hi (0x0) and hash_key_lo (0x8)
// while the core is idle. Each input word is taken into a two-entry queue,
// so s_tready stays high while the queue has room. Absorb and finish words
// occupy the shared 128x32 carry-less multiplier (one 32-bit digit of H per
// cycle); clear and zero-count words bypass it. A new block enters the
// multiplier only once the previous product is done. An accepted word passes
// through the queue register to the back end, whose output register drives
// m_tvalid and holds each result until m_tready. m_tlast marks the result of a
// finish word.
`timescale 1ns / 1ps
`default_nettype none

module ghash_accumulator_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // APB
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [ghacc_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [ghacc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ghacc_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                   pready,
    // input words
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [63:0] block_hi, [127:64] block_lo, [132:128] byte_count, rest zero
    input  wire logic [ghacc_pkg::S_TDATA_W-1:0]   s_tdata,
    // [1:0] command
    input  wire logic [ghacc_pkg::CMD_W-1:0]       s_tuser,
    // result words
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [63:0] hash_hi, [127:64] hash_lo
    output logic [ghacc_pkg::BLOCK_W-1:0]          m_tdata,
    output logic                                   m_tlast
);
    import ghacc_pkg::*;

    logic [HALF_W-1:0]  key_hi_reg, key_lo_reg;
    logic               cfg_write;
    reg_idx_t           reg_idx;

    logic               accept;
    qentry_t            front_entry;
    qentry_t            head_entry;
    logic               q_full, q_empty, q_pop;
    logic [BLOCK_W-1:0] hash;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = paddr[APB_ADDR_W-1:REG_LSB];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_hi_reg <= '0;
            key_lo_reg <= '0;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_KEY_HI: key_hi_reg <= pwdata;
                REG_KEY_LO: key_lo_reg <= pwdata;
                default:    key_hi_reg <= key_hi_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_KEY_HI: prdata = key_hi_reg;
            REG_KEY_LO: prdata = key_lo_reg;
            default:    prdata = '0;
        endcase
    end

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    ghacc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .command    (s_tuser),
        .block_hi   (s_tdata[HALF_W-1:0]),
        .block_lo   (s_tdata[BLOCK_W-1:HALF_W]),
        .byte_count (s_tdata[BLOCK_W+BCNT_W-1:BLOCK_W]),
        .entry      (front_entry)
    );

    ghacc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (accept),
        .wr_entry (front_entry),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .rd_entry (head_entry)
    );

    ghacc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .hash_key  ({key_hi_reg, key_lo_reg}),
        .head      (head_entry),
        .empty     (q_empty),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_hash  (hash),
        .out_final (m_tlast)
    );

    assign m_tdata = {hash[HALF_W-1:0], hash[BLOCK_W-1:HALF_W]};

endmodule

`default_nettype wire

>>> src/ghacc_front.sv
// Front end: classifies each accepted word, masks the block, keeps the
// AAD and text byte counters and builds the lengths block. Uses ghacc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ghacc_front (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    accept,
    input  wire ghacc_pkg::cmd_t         command,
    input  wire logic [63:0]             block_hi,
    input  wire logic [63:0]             block_lo,
    input  wire logic [4:0]              byte_count,
    output ghacc_pkg::qentry_t           entry
);
    import ghacc_pkg::*;

    logic [BCNT_W-1:0]  n_sat;
    logic [BLOCK_W-1:0] mask;
    logic [CNT_W-1:0]   aad_bytes_reg, aad_bytes_next;
    logic [CNT_W-1:0]   text_bytes_reg, text_bytes_next;
    logic [CNT_W-1:0]   aad_bits, text_bits;

    assign n_sat = (byte_count > BCNT_W'(BLOCK_BYTES)) ? BCNT_W'(BLOCK_BYTES) : byte_count;

    // byte 0 sits in the top bits
    always_comb begin
        for (int b = 0; b < BLOCK_BYTES; b++) begin
            mask[BLOCK_W-1-8*b -: 8] = {8{(BCNT_W'(b) < n_sat)}};
        end
    end

    assign aad_bits  = aad_bytes_reg << 3;
    assign text_bits = text_bytes_reg << 3;

    always_comb begin
        entry           = '0;
        aad_bytes_next  = aad_bytes_reg;
        text_bytes_next = text_bytes_reg;
        unique case (command) inside
            CMD_CLEAR: begin
                entry.op        = OP_CLEAR;
                aad_bytes_next  = '0;
                text_bytes_next = '0;
            end
            CMD_AAD, CMD_TEXT: begin
                entry.op   = (n_sat == '0) ? OP_PASS : OP_MUL;
                entry.data = {block_hi, block_lo} & mask;
                if (command == CMD_AAD) begin
                    aad_bytes_next = aad_bytes_reg + CNT_W'(n_sat);
                end else begin
                    text_bytes_next = text_bytes_reg + CNT_W'(n_sat);
                end
            end
            CMD_FINISH: begin
                entry.op   = OP_MUL;
                entry.fin  = 1'b1;
                entry.data = {CNT_W'(0), aad_bits, CNT_W'(0), text_bits};
            end
            default: begin
                entry.op = OP_PASS;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            aad_bytes_reg  <= '0;
            text_bytes_reg <= '0;
        end else if (accept) begin
            aad_bytes_reg  <= aad_bytes_next;
            text_bytes_reg <= text_bytes_next;
        end
    end

endmodule

`default_nettype wire

>>> src/ghacc_queue.sv
// Short in-order queue between front and back end.
// Entry type and depth from ghacc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ghacc_queue (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire ghacc_pkg::qentry_t  wr_entry,
    output logic                     full,
    input  wire logic                pop,
    output logic                     empty,
    output ghacc_pkg::qentry_t       rd_entry
);
    import ghacc_pkg::*;

    qentry_t            entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign rd_entry = entries_reg[rd_ptr_reg];

    assign count_next = count_reg + QCNT_W'(push) - QCNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> src/ghacc_back.sv
// Back end: holds the accumulator and runs the digit-serial GF(2^128)
// multiply by H, one 32-bit digit of H per cycle. Uses ghacc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ghacc_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [ghacc_pkg::BLOCK_W-1:0] hash_key,
    input  wire ghacc_pkg::qentry_t            head,
    input  wire logic                          empty,
    output logic                               q_pop,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [ghacc_pkg::BLOCK_W-1:0]      out_hash,
    output logic                               out_final
);
    import ghacc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_HOLD
    } state_t;

    // reflected (GCM) order <-> normal polynomial order
    function automatic logic [BLOCK_W-1:0] bit_rev(input logic [BLOCK_W-1:0] v);
        logic [BLOCK_W-1:0] r;
        for (int k = 0; k < BLOCK_W; k++) begin
            r[k] = v[BLOCK_W-1-k];
        end
        return r;
    endfunction

    // z*x^DIGIT_W + a*d, reduced; normal order
    function automatic logic [BLOCK_W-1:0] gf_step(input logic [BLOCK_W-1:0] z,
                                                   input logic [BLOCK_W-1:0] a,
                                                   input logic [DIGIT_W-1:0] d);
        logic [BLOCK_W+DIGIT_W-1:0] t;
        logic [BLOCK_W-1:0]         top;
        logic [BLOCK_W-1:0]         res;
        t = {z, DIGIT_W'(0)};
        for (int j = 0; j < DIGIT_W; j++) begin
            if (d[j]) begin
                t = t ^ ((BLOCK_W + DIGIT_W)'(a) << j);
            end
        end
        top = BLOCK_W'(t[BLOCK_W+DIGIT_W-1 -: DIGIT_W]);
        res = t[BLOCK_W-1:0];
        for (int k = 0; k < 8; k++) begin
            if (GF_POLY_LO[k]) begin
                res = res ^ (top << k);
            end
        end
        return res;
    endfunction

    state_t                state_reg, state_next;
    logic [BLOCK_W-1:0]    acc_reg, acc_next;
    logic [BLOCK_W-1:0]    a_reg, a_next;
    logic [BLOCK_W-1:0]    z_reg, z_next;
    logic [DIG_IDX_W-1:0]  dcnt_reg, dcnt_next;
    logic                  fin_reg, fin_next;
    logic                  out_valid_reg, out_valid_next;
    logic [BLOCK_W-1:0]    out_hash_reg, out_hash_next;
    logic                  out_final_reg, out_final_next;

    logic [BLOCK_W-1:0]    h_norm;
    logic [BLOCK_W-1:0]    a_start;
    logic [BLOCK_W-1:0]    step_a, step_z, step_out;
    logic [DIG_IDX_W-1:0]  step_idx;
    logic [DIGIT_W-1:0]    step_d;
    logic                  out_free;
    logic                  pop;

    assign h_norm   = bit_rev(hash_key);
    assign a_start  = bit_rev(acc_reg ^ head.data);
    assign step_a   = (state_reg == ST_IDLE) ? a_start : a_reg;
    assign step_z   = (state_reg == ST_IDLE) ? '0 : z_reg;
    assign step_idx = (state_reg == ST_IDLE) ? DIG_IDX_W'(DIGITS - 1) : dcnt_reg;
    assign step_d   = h_norm[DIGIT_W*step_idx +: DIGIT_W];
    assign step_out = gf_step(step_z, step_a, step_d);
    assign out_free = !out_valid_reg || out_ready;

    always_comb begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        a_next         = a_reg;
        z_next         = z_reg;
        dcnt_next      = dcnt_reg;
        fin_next       = fin_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_hash_next  = out_hash_reg;
        out_final_next = out_final_reg;
        pop            = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (!empty) begin
                    case (head.op)
                        OP_CLEAR: begin
                            if (out_free) begin
                                pop            = 1'b1;
                                acc_next       = '0;
                                out_valid_next = 1'b1;
                                out_hash_next  = '0;
                                out_final_next = head.fin;
                            end
                        end
                        OP_MUL: begin
                            pop        = 1'b1;
                            a_next     = a_start;
                            z_next     = step_out;
                            dcnt_next  = DIG_IDX_W'(DIGITS - 2);
                            fin_next   = head.fin;
                            state_next = ST_MUL;
                        end
                        default: begin
                            if (out_free) begin
                                pop            = 1'b1;
                                out_valid_next = 1'b1;
                                out_hash_next  = acc_reg;
                                out_final_next = head.fin;
                            end
                        end
                    endcase
                end
            end
            ST_MUL: begin
                z_next    = step_out;
                dcnt_next = dcnt_reg - DIG_IDX_W'(1);
                if (dcnt_reg == '0) begin
                    acc_next = bit_rev(step_out);
                    if (out_free) begin
                        out_valid_next = 1'b1;
                        out_hash_next  = bit_rev(step_out);
                        out_final_next = fin_reg;
                        state_next     = ST_IDLE;
                    end else begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_hash_next  = acc_reg;
                    out_final_next = fin_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            dcnt_reg      <= '0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_final_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            dcnt_reg      <= dcnt_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
            out_final_reg <= out_final_next;
        end
        a_reg        <= a_next;
        z_reg        <= z_next;
        out_hash_reg <= out_hash_next;
    end

    assign q_pop     = pop;
    assign out_valid = out_valid_reg;
    assign out_hash  = out_hash_reg;
    assign out_final = out_final_reg;

    a_pop_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (state_reg == ST_IDLE) && !empty)
        else $error("queue popped outside idle or while empty");

    a_hold_has_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HOLD) |-> out_valid_reg)
        else $error("holding a result with the output register free");

    a_clear_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && head.op == OP_CLEAR) |=> (acc_reg == '0) && out_valid_reg)
        else $error("clear did not zero the accumulator");

    a_mul_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL && dcnt_reg == '0 && !out_free) |=> (state_reg == ST_HOLD))
        else $error("multiply result lost while output stalled");

endmodule

`default_nettype wire

>>> bench/ghash_accumulator_core_tb.sv
// Self-checking bench for ghash_accumulator_core: APB key set-up, GHASH stream in, hash words out.
// Expected words: in-bench GF(2^128) predictor or typed table rows. Needs ghacc_pkg and the core RTL.
`timescale 1ns / 1ps

module ghash_accumulator_core_tb;
    import ghacc_pkg::*;

    localparam logic [63:0]  ONES      = {64{1'b1}};
    localparam logic [127:0] GF_REDUCE = {8'hE1, 120'd0};
    localparam int           SEG_WORDS = 320;
    localparam int           HOLD_LEN  = 300;

    typedef struct packed {
        logic [63:0] hash_hi;
        logic [63:0] hash_lo;
        logic        fin;
    } hash_word_t;

    typedef enum logic { ROW_ITEM, ROW_KEY } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        cmd_t        cmd;
        logic [63:0] blk_hi;   // key hi on ROW_KEY
        logic [63:0] blk_lo;   // key lo on ROW_KEY
        logic [4:0]  cnt;
        logic        typed;
        logic [63:0] want_hi;
        logic [63:0] want_lo;
        logic        want_fin;
    } dir_row_t;

    // typed rows: key of zero, then the unit element so the hash is a plain XOR; later typed rows expect a zero hash
    localparam dir_row_t DIR_ROWS [28] = '{
        '{ROW_ITEM, CMD_AAD,    ONES, ONES, 5'd16, 1'b1, 64'd0, 64'd0, 1'b0},
        '{ROW_ITEM, CMD_FINISH, 64'd0, 64'd0, 5'd0, 1'b1, 64'd0, 64'd0, 1'b1},
        '{ROW_ITEM, CMD_CLEAR,  64'd0, 64'd0, 5'd0, 1'b1, 64'd0, 64'd0, 1'b0},
        '{ROW_KEY,  CMD_CLEAR,  64'h8000_0000_0000_0000, 64'd0, 5'd0, 1'b0, 64'd0, 64'd0, 1'b0},
        '{ROW_ITEM, CMD_AAD, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 5'd16, 1'b1,
          64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 1'b0},
        '{ROW_ITEM, CMD_TEXT, ONES, ONES, 5'd0, 1'b1,
          64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 1'b0},
        '{ROW_ITEM, CMD_TEXT, ONES, ONES, 5'd5, 1'b1,
          64'hfedc_ba98_76ab_cdef, 64'hfedc_ba98_7654_3210, 1'b0},
        '{ROW_ITEM, CMD_AAD, ONES, ONES, 5'd31, 1'b1,
          64'h0123_4567_8954_3210, 64'h0123_4567_89ab_cdef, 1'b0},
        '{ROW_ITEM, CMD_FINISH, ONES, ONES, 5'd31, 1'b1,
          64'h0123_4567_8954_3310, 64'h0123_4567_89ab_cdc7, 1'b1},
        '{ROW_ITEM, CMD_FINISH, 64'd0, 64'd0, 5'd0, 1'b1,
          64'h0123_4567_8954_3210, 64'h0123_4567_89ab_cdef, 1'b1},
        '{ROW_ITEM, CMD_CLEAR, ONES, ONES, 5'd16, 1'b1, 64'd0, 64'd0, 1'b0},
        '{ROW_ITEM, CMD_TEXT, ONES, ONES, 5'd9, 1'b1, ONES, 64'hff00_0000_0000_0000, 1'b0},
        '{ROW_ITEM, CMD_AAD, 64'haaaa_aaaa_aaaa_aaaa, ONES, 5'd8, 1'b1,
          64'h5555_5555_5555_5555, 64'hff00_0000_0000_0000, 1'b0},
        '{ROW_ITEM, CMD_AAD, ONES, 64'd0, 5'd1, 1'b1,
          64'haa55_5555_5555_5555, 64'hff00_0000_0000_0000, 1'b0},
        '{ROW_ITEM, CMD_FINISH, 64'd0, 64'd0, 5'd0, 1'b1,
          64'haa55_5555_5555_551d, 64'hff00_0000_0000_0048, 1'b1},
        '{ROW_KEY,  CMD_CLEAR, ONES, ONES, 5'd0, 1'b0, 64'd0, 64'd0, 1'b0},
        '{ROW_ITEM, CMD_AAD, ONES, ONES, 5'd16, 1'b0, 64'd0, 64'd0, 1'b0},
        '{ROW_ITEM, CMD_TEXT, 64'h8000_0000_0000_0000, 64'd1, 5'd16, 1'b0, 64'd0, 64'd0, 1'b0},
        '{ROW_ITEM, CMD_AAD, 64'h0f1e_2d3c_4b5a_6978, 64'h8796_a5b4_c3d2_e1f0, 5'd17, 1'b0,
          64'd0, 64'd0, 1'b0},
        '{ROW_ITEM, CMD_FINISH, ONES, 64'd0, 5'd3, 1'b0, 64'd0, 64'd0, 1'b0},
        '{ROW_ITEM, CMD_CLEAR, 64'd0, ONES, 5'd7, 1'b1, 64'd0, 64'd0, 1'b0},
        '{ROW_ITEM, CMD_TEXT, 64'd0, 64'd0, 5'd16, 1'b1, 64'd0, 64'd0, 1'b0},
        '{ROW_KEY,  CMD_CLEAR, 64'h66e9_4bd4_ef8a_2c3b, 64'h884c_fa59_ca34_2b2e, 5'd0, 1'b0,
          64'd0, 64'd0, 1'b0},
        '{ROW_ITEM, CMD_AAD, 64'hfeed_face_dead_beef, 64'habad_dad2_0000_0000, 5'd13, 1'b0,
          64'd0, 64'd0, 1'b0},
        '{ROW_ITEM, CMD_TEXT, 64'hd931_3225_f884_06e5, 64'ha559_09c5_aff5_269a, 5'd16, 1'b0,
          64'd0, 64'd0, 1'b0},
        '{ROW_ITEM, CMD_TEXT, ONES, ONES, 5'd0, 1'b0, 64'd0, 64'd0, 1'b0},
        '{ROW_ITEM, CMD_FINISH, 64'd0, 64'd0, 5'd16, 1'b0, 64'd0, 64'd0, 1'b0},
        '{ROW_ITEM, CMD_CLEAR, ONES, ONES, 5'd31, 1'b1, 64'd0, 64'd0, 1'b0}
    };

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;   // [63:0] block_hi, [127:64] block_lo, [132:128] byte_count
    cmd_t                  s_tuser  = CMD_CLEAR;   // [1:0] command
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [BLOCK_W-1:0]    m_tdata;   // [63:0] hash_hi, [127:64] hash_lo
    logic                  m_tlast;

    // predictor state
    logic [127:0] hash_key = '0;
    logic [127:0] hash_acc = '0;
    logic [31:0]  aad_len  = '0;
    logic [31:0]  text_len = '0;

    hash_word_t   hash_due[$];
    int           errors    = 0;
    int           words_in  = 0;
    int           send_idle = 0;
    int           recv_idle = 0;
    int           hold_reqs = 0;
    int           hold_seen = 0;
    int           hold_left = 0;

    ghash_accumulator_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // x * h in GF(2^128), MSB of the vector is the x^0 coefficient
    function automatic logic [127:0] gf128_mul(logic [127:0] x, logic [127:0] h);
        logic [127:0] z;
        logic [127:0] v;
        z = '0;
        v = x;
        for (int i = 0; i < 128; i++) begin
            if (h[127 - i])
                z ^= v;
            v = v[0] ? ((v >> 1) ^ GF_REDUCE) : (v >> 1);
        end
        return z;
    endfunction

    task automatic ghash_step(input cmd_t cmd, input logic [63:0] bhi, input logic [63:0] blo,
                              input logic [4:0] cnt, output hash_word_t w);
        logic [4:0]   n;
        logic [127:0] mask;
        n = (cnt > 5'd16) ? 5'd16 : cnt;
        case (cmd)
            CMD_CLEAR: begin
                hash_acc = '0;
                aad_len  = '0;
                text_len = '0;
            end
            CMD_AAD, CMD_TEXT: begin
                if (n != 0) begin
                    mask     = ~128'd0 << (8 * (16 - n));
                    hash_acc = gf128_mul(hash_acc ^ ({bhi, blo} & mask), hash_key);
                    if (cmd == CMD_AAD)
                        aad_len += n;
                    else
                        text_len += n;
                end
            end
            default: begin
                hash_acc = gf128_mul(hash_acc ^ {32'd0, aad_len << 3, 32'd0, text_len << 3},
                                     hash_key);
            end
        endcase
        w.hash_hi = hash_acc[127:64];
        w.hash_lo = hash_acc[63:0];
        w.fin     = (cmd == CMD_FINISH);
    endtask

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        errors++;
        if (errors <= 10)
            $display("mismatch %0s: expected %h, got %h at %0t", what, want, got, $time);
    endtask

    task automatic apb_xfer(input reg_idx_t idx, input logic wr, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, {REG_LSB{1'b0}}};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (!wr && prdata !== value)
            note_mismatch("key readback", value, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_hash_key(input logic [63:0] khi, input logic [63:0] klo);
        apb_xfer(REG_KEY_HI, 1'b1, khi);
        apb_xfer(REG_KEY_LO, 1'b1, klo);
        apb_xfer(REG_KEY_HI, 1'b0, khi);
        apb_xfer(REG_KEY_LO, 1'b0, klo);
        hash_key = {khi, klo};
    endtask

    // caller has already dropped s_tvalid
    task automatic wait_idle();
        while (hash_due.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    // returns at the edge the word is taken; s_tvalid left high
    task automatic send_word(input cmd_t cmd, input logic [63:0] bhi, input logic [63:0] blo,
                             input logic [4:0] cnt);
        logic [S_TDATA_W-1:0] word;
        if ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle) @(posedge aclk);
        end
        word = '0;
        word[63:0]    = bhi;
        word[127:64]  = blo;
        word[132:128] = cnt;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        words_in++;
    endtask

    task automatic send_predicted(input cmd_t cmd, input logic [63:0] bhi,
                                  input logic [63:0] blo, input logic [4:0] cnt);
        hash_word_t w;
        send_word(cmd, bhi, blo, cnt);
        ghash_step(cmd, bhi, blo, cnt, w);
        hash_due.push_back(w);
    endtask

    // optional clear, AAD blocks, text blocks, finish; last block of each part may be short
    task automatic send_message();
        int n_aad;
        int n_text;
        n_aad  = $urandom_range(0, 4);
        n_text = $urandom_range(0, 6);
        if ($urandom_range(9) != 0)
            send_predicted(CMD_CLEAR, rand64(), rand64(), 5'($urandom_range(0, 31)));
        for (int i = 0; i < n_aad; i++)
            send_predicted(CMD_AAD, rand64(), rand64(),
                           (i == n_aad - 1) ? 5'($urandom_range(1, 16)) : 5'd16);
        for (int i = 0; i < n_text; i++)
            send_predicted(CMD_TEXT, rand64(), rand64(),
                           (i == n_text - 1) ? 5'($urandom_range(1, 16)) : 5'd16);
        send_predicted(CMD_FINISH, rand64(), rand64(), 5'($urandom_range(0, 31)));
    endtask

    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_seen != hold_reqs) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_LEN;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge aclk) begin
        hash_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (hash_due.size() == 0) begin
                note_mismatch("unexpected word", 64'd0, m_tdata[63:0]);
            end else begin
                want = hash_due.pop_front();
                if (m_tdata[63:0] !== want.hash_hi)
                    note_mismatch("hash_hi", want.hash_hi, m_tdata[63:0]);
                if (m_tdata[127:64] !== want.hash_lo)
                    note_mismatch("hash_lo", want.hash_lo, m_tdata[127:64]);
                if (m_tlast !== want.fin)
                    note_mismatch("final", {63'd0, want.fin}, {63'd0, m_tlast});
            end
        end
    end

    initial begin
        hash_word_t w;
        dir_row_t   row;
        int         seg_start;
        logic [63:0] khi;
        logic [63:0] klo;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle = 37;
        recv_idle = 70;
        foreach (DIR_ROWS[r]) begin
            row = DIR_ROWS[r];
            if (row.kind == ROW_KEY) begin
                s_tvalid <= 1'b0;
                wait_idle();
                set_hash_key(row.blk_hi, row.blk_lo);
            end else begin
                send_word(row.cmd, row.blk_hi, row.blk_lo, row.cnt);
                ghash_step(row.cmd, row.blk_hi, row.blk_lo, row.cnt, w);
                if (row.typed) begin
                    w.hash_hi = row.want_hi;
                    w.hash_lo = row.want_lo;
                    w.fin     = row.want_fin;
                end
                hash_due.push_back(w);
            end
        end

        for (int seg = 0; seg < 6; seg++) begin
            s_tvalid <= 1'b0;
            wait_idle();
            case (seg)
                1:       begin khi = ONES;  klo = ONES;  end
                3:       begin khi = 64'd0; klo = 64'd1; end
                default: begin khi = rand64(); klo = rand64(); end
            endcase
            set_hash_key(khi, klo);
            case (seg / 2)
                0:       begin send_idle = 37; recv_idle = 70; end
                1:       begin send_idle = 70; recv_idle = 37; end
                default: begin send_idle = 0;  recv_idle = 0;  end
            endcase
            if (seg == 4)
                hold_reqs <= hold_reqs + 1;   // long back-pressure, sender keeps offering
            seg_start = words_in;
            while (words_in - seg_start < SEG_WORDS) begin
                if ($urandom_range(99) < 85)
                    send_message();
                else
                    send_predicted(cmd_t'($urandom_range(0, 3)), rand64(), rand64(),
                                   5'($urandom_range(0, 31)));
            end
        end
        s_tvalid <= 1'b0;

        while (hash_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0 && hash_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
